@@ hdl/whp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// whp_pkg: shared types, widths and register codes of the window histogram
// percentile block. No dependencies; imported by all modules but whp_ram.
package whp_pkg;

   localparam int HIST_BINS       = 256;
   localparam int BIN_W           = 8;
   localparam int CNT_W           = 21;
   localparam int SUM_W           = CNT_W + BIN_W;
   localparam int MAX_DIM         = 1024;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int CSR_ADDR_W      = 5;
   localparam int CSR_DATA_W      = 32;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
   localparam logic [BIN_W-1:0] BIN_MAX = BIN_W'(HIST_BINS - 1);

   typedef enum logic [2:0] {
      REG_IMAGE_ROWS = 3'd0,
      REG_IMAGE_COLS = 3'd1,
      REG_WIN_TOP    = 3'd2,
      REG_WIN_BOTTOM = 3'd3,
      REG_WIN_LEFT   = 3'd4,
      REG_WIN_RIGHT  = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [9:0]         pixel_row;
      logic [9:0]         pixel_col;
      logic signed [15:0] disparity;
      logic               frame_end;
   } req_data_type;

   typedef struct packed {
      logic [BIN_W-1:0] selected_disparity;
      logic [CNT_W-1:0] valid_total;
   } rsp_data_type;

   typedef struct packed {
      logic             count;
      logic [BIN_W-1:0] bin;
      logic             last;
   } queue_entry_type;

   typedef struct packed {
      logic clearing;
      logic queue_full;
   } back_status_type;

endpackage : whp_pkg
`default_nettype wire

@@ hdl/whp_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// whp_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module whp_ram #(
   parameter int WIDTH = 21,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule : whp_ram
`default_nettype wire

@@ hdl/whp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// whp_front: configuration registers, pixel intake and window/bin classification.
// Depends on whp_pkg.
module whp_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire whp_pkg::req_data_type          req_data,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [whp_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [whp_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [whp_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                pready,
   input  wire whp_pkg::back_status_type       status,
   output logic                                push,
   output whp_pkg::queue_entry_type            push_entry
);
   import whp_pkg::*;

   logic [10:0]        rows_ff, rows_in, cols_ff, cols_in;
   logic signed [11:0] top_ff, top_in, bottom_ff, bottom_in;
   logic signed [11:0] left_ff, left_in, right_ff, right_in;
   logic               wr;
   reg_index_type      idx;
   logic signed [11:0] row_s, col_s;
   logic               in_rows, in_cols, positive;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign idx    = reg_index_type'(paddr[4:2]);

   always_comb begin
      rows_in   = rows_ff;
      cols_in   = cols_ff;
      top_in    = top_ff;
      bottom_in = bottom_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      if (wr) begin
         unique case (idx)
            REG_IMAGE_ROWS: rows_in   = pwdata[10:0];
            REG_IMAGE_COLS: cols_in   = pwdata[10:0];
            REG_WIN_TOP:    top_in    = $signed(pwdata[11:0]);
            REG_WIN_BOTTOM: bottom_in = $signed(pwdata[11:0]);
            REG_WIN_LEFT:   left_in   = $signed(pwdata[11:0]);
            REG_WIN_RIGHT:  right_in  = $signed(pwdata[11:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff   <= 11'd1024;
         cols_ff   <= 11'd1024;
         top_ff    <= 12'sd0;
         bottom_ff <= 12'sd1023;
         left_ff   <= 12'sd0;
         right_ff  <= 12'sd1023;
      end else begin
         rows_ff   <= rows_in;
         cols_ff   <= cols_in;
         top_ff    <= top_in;
         bottom_ff <= bottom_in;
         left_ff   <= left_in;
         right_ff  <= right_in;
      end
   end

   always_comb begin
      prdata = '0;
      unique case (idx)
         REG_IMAGE_ROWS: prdata = {21'd0, rows_ff};
         REG_IMAGE_COLS: prdata = {21'd0, cols_ff};
         REG_WIN_TOP:    prdata = {20'd0, top_ff};
         REG_WIN_BOTTOM: prdata = {20'd0, bottom_ff};
         REG_WIN_LEFT:   prdata = {20'd0, left_ff};
         REG_WIN_RIGHT:  prdata = {20'd0, right_ff};
         default:        prdata = '0;
      endcase
   end

   // negative window edges clamp to zero for free: coordinates are never negative
   assign row_s    = $signed({2'b00, req_data.pixel_row});
   assign col_s    = $signed({2'b00, req_data.pixel_col});
   assign in_rows  = (row_s >= top_ff) && (row_s <= bottom_ff)
                     && ({1'b0, req_data.pixel_row} < rows_ff)
                     && (32'(req_data.pixel_row) < MAX_DIM);
   assign in_cols  = (col_s >= left_ff) && (col_s <= right_ff)
                     && ({1'b0, req_data.pixel_col} < cols_ff)
                     && (32'(req_data.pixel_col) < MAX_DIM);
   assign positive = !req_data.disparity[15] && (req_data.disparity != 16'sd0);

   always_comb begin
      push_entry.count = positive && in_rows && in_cols;
      push_entry.bin   = (|req_data.disparity[14:8]) ? BIN_MAX : req_data.disparity[7:0];
      push_entry.last  = req_data.frame_end;
   end

   assign req_stall = status.queue_full || status.clearing;
   // words that neither count nor close a frame are dropped here
   assign push      = req_valid && !req_stall && (push_entry.count || push_entry.last);

endmodule : whp_front
`default_nettype wire

@@ hdl/whp_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// whp_queue: short FIFO of classified words between front and back.
// Depends on whp_pkg.
module whp_queue #(
   parameter int DEPTH = whp_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire whp_pkg::queue_entry_type push_entry,
   input  wire logic                     pop,
   output logic                          not_empty,
   output logic                          full,
   output whp_pkg::queue_entry_type      head
);
   import whp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_QW = $clog2(DEPTH + 1);

   queue_entry_type   slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0] fill_ff, fill_in;

   assign not_empty = (fill_ff != '0);
   assign full      = (fill_ff == CNT_QW'(DEPTH));
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule : whp_queue
`default_nettype wire

@@ hdl/whp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// whp_back: histogram update, end-of-frame percentile scan and result register.
// Depends on whp_pkg and whp_ram.
module whp_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     q_not_empty,
   input  wire whp_pkg::queue_entry_type q_head,
   output logic                          q_pop,
   output logic                          clearing,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output whp_pkg::rsp_data_type         rsp_data
);
   import whp_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [BIN_W-1:0] clr_addr_ff, clr_addr_in;
   logic             b_valid_ff, b_valid_in;
   queue_entry_type  b_entry_ff, b_entry_in;
   logic             w_valid_ff, w_valid_in;
   logic [BIN_W-1:0] w_addr_ff, w_addr_in;
   logic [CNT_W-1:0] w_data_ff, w_data_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [BIN_W-1:0] scan_rd_ff, scan_rd_in;
   logic             scan_issue_ff, scan_issue_in;
   logic             dv_ff, dv_in;
   logic [BIN_W-1:0] daddr_ff, daddr_in;
   logic [SUM_W-1:0] sum_ff, sum_in, sum_nx;
   logic [SUM_W+2:0] sum_x5;
   logic [BIN_W-1:0] sel_ff, sel_in;
   logic             found_ff, found_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_data_type     rsp_data_ff, rsp_data_in;

   logic             ram_we;
   logic [BIN_W-1:0] ram_waddr, ram_raddr;
   logic [CNT_W-1:0] ram_wdata, ram_rdata, bin_old, bin_new;

   whp_ram #(
      .WIDTH(CNT_W),
      .DEPTH(HIST_BINS)
   ) u_hist (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign clearing  = (state_ff == ST_CLEAR);
   assign q_pop     = (state_ff == ST_RUN) && q_not_empty
                      && !(b_valid_ff && b_entry_ff.last);
   assign ram_raddr = (state_ff == ST_SCAN) ? scan_rd_ff : q_head.bin;

   // bypass the write of the previous cycle, which the registered read missed
   assign bin_old = (w_valid_ff && (w_addr_ff == b_entry_ff.bin)) ? w_data_ff : ram_rdata;
   assign bin_new = (bin_old == CNT_MAX) ? bin_old : bin_old + 1'b1;
   assign sum_nx  = sum_ff + SUM_W'(ram_rdata);
   assign sum_x5  = {1'b0, sum_nx, 2'b00} + {3'b000, sum_nx};

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      b_valid_in    = 1'b0;
      b_entry_in    = q_pop ? q_head : b_entry_ff;
      w_valid_in    = 1'b0;
      w_addr_in     = b_entry_ff.bin;
      w_data_in     = bin_new;
      total_in      = total_ff;
      scan_rd_in    = scan_rd_ff;
      scan_issue_in = scan_issue_ff;
      dv_in         = 1'b0;
      daddr_in      = scan_rd_ff;
      sum_in        = sum_ff;
      sel_in        = sel_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_waddr     = clr_addr_ff;
      ram_wdata     = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we      = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == BIN_MAX) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            b_valid_in = q_pop;
            if (b_valid_ff && b_entry_ff.count) begin
               ram_we     = 1'b1;
               ram_waddr  = b_entry_ff.bin;
               ram_wdata  = bin_new;
               w_valid_in = 1'b1;
               if (total_ff != CNT_MAX) begin
                  total_in = total_ff + 1'b1;
               end
            end
            if (b_valid_ff && b_entry_ff.last) begin
               state_in      = ST_SCAN;
               scan_rd_in    = BIN_MAX;
               scan_issue_in = 1'b1;
               sum_in        = '0;
               sel_in        = '0;
               found_in      = 1'b0;
            end
         end
         ST_SCAN: begin
            if (scan_issue_ff) begin
               dv_in = 1'b1;
               if (scan_rd_ff == '0) begin
                  scan_issue_in = 1'b0;
               end else begin
                  scan_rd_in = scan_rd_ff - 1'b1;
               end
            end
            if (dv_ff) begin
               ram_we    = 1'b1;
               ram_waddr = daddr_ff;
               sum_in    = sum_nx;
               // sum > total/5 is the same as 5*sum > total
               if (!found_ff && (sum_x5 > (SUM_W+3)'(total_ff))) begin
                  found_in = 1'b1;
                  sel_in   = daddr_ff;
               end
               if (daddr_ff == '0) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                   = 1'b1;
               rsp_data_in.selected_disparity = sel_ff;
               rsp_data_in.valid_total        = total_ff;
               total_in                       = '0;
               state_in                       = ST_RUN;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         b_valid_ff    <= 1'b0;
         w_valid_ff    <= 1'b0;
         total_ff      <= '0;
         scan_issue_ff <= 1'b0;
         dv_ff         <= 1'b0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         b_valid_ff    <= b_valid_in;
         w_valid_ff    <= w_valid_in;
         total_ff      <= total_in;
         scan_issue_ff <= scan_issue_in;
         dv_ff         <= dv_in;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_entry_ff  <= b_entry_in;
      w_addr_ff   <= w_addr_in;
      w_data_ff   <= w_data_in;
      scan_rd_ff  <= scan_rd_in;
      daddr_ff    <= daddr_in;
      sum_ff      <= sum_in;
      sel_ff      <= sel_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule : whp_back
`default_nettype wire

@@ hdl/window_histogram_percentile.sv @@
`timescale 1ns / 1ps
`default_nettype none
// window_histogram_percentile: top level, front classifier, word queue and
// histogram back end. Depends on whp_pkg, whp_front, whp_queue, whp_back.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall  req_data_type (row, col, disparity, frame_end)
//   rsp      out        rsp_valid/rsp_stall  rsp_data_type (selected_disparity, valid_total)
//   csr      in         psel/penable/pready  paddr, pwdata, prdata (6 regs at 4*i)
//
// Pixels are taken one per cycle while req_stall is low; in its run state the back end
// updates one histogram bin per cycle while the queue holds words, through a
// read-modify-write on the histogram RAM with a one-word bypass. A frame end starts a
// 256-bin scan through the RAM read port that also zeroes each bin, then the result is
// loaded once the result register is free. After reset a clearing pass zeroes the
// histogram; req_stall is high then, and also while the queue is full, e.g. in the scan.
module window_histogram_percentile #(
   parameter int QUEUE_DEPTH = whp_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire whp_pkg::req_data_type          req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output whp_pkg::rsp_data_type               rsp_data,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [whp_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [whp_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [whp_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                pready
);
   import whp_pkg::*;

   back_status_type status;
   logic            push, pop, q_not_empty, q_full, clearing;
   queue_entry_type push_entry, q_head;

   assign status.clearing   = clearing;
   assign status.queue_full = q_full;

   whp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .status    (status),
      .push      (push),
      .push_entry(push_entry)
   );

   whp_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .not_empty (q_not_empty),
      .full      (q_full),
      .head      (q_head)
   );

   whp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_not_empty(q_not_empty),
      .q_head     (q_head),
      .q_pop      (pop),
      .clearing   (clearing),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule : window_histogram_percentile
`default_nettype wire
